FILE: src/npir_pkg.sv
package npir_pkg;

   // palette geometry
   localparam int PAL_TABLE_SIZE  = 16;
   localparam int PALETTE_ENTRIES = 16;
   localparam int ENTRY_COUNT     = (PALETTE_ENTRIES < 1) ? 1 :
                                    ((PALETTE_ENTRIES > PAL_TABLE_SIZE) ? PAL_TABLE_SIZE :
                                     PALETTE_ENTRIES);
   localparam int IDX_W           = $clog2(PAL_TABLE_SIZE);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRY_COUNT - 1);

   // field widths
   localparam int CHAN_W = 8;
   localparam int SQ_W   = 2 * CHAN_W;
   localparam int DIST_W = 18;
   localparam int BYTE_W = 8;

   // frame constants
   localparam logic [BYTE_W-1:0] IR_ADDR_BYTE    = 8'h00;
   localparam logic [BYTE_W-1:0] IR_ADDR_INVERSE = 8'hFF;

   // register map
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_DARK_THRESHOLD = 1'b0;   // word index, paddr[2]
   localparam logic [CHAN_W-1:0] DARK_THRESHOLD_RESET = 8'd25;

   // palette colors and their remote command codes
   localparam logic [CHAN_W-1:0] PAL_RED [PAL_TABLE_SIZE] = '{
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
      8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd255};
   localparam logic [CHAN_W-1:0] PAL_GREEN [PAL_TABLE_SIZE] = '{
      8'd255, 8'd191, 8'd127, 8'd63,  8'd0,   8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd63,  8'd127, 8'd191, 8'd255, 8'd255, 8'd255};
   localparam logic [CHAN_W-1:0] PAL_BLUE [PAL_TABLE_SIZE] = '{
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd63,  8'd127, 8'd191,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd191, 8'd127, 8'd0,   8'd255};
   localparam logic [BYTE_W-1:0] PAL_CODE [PAL_TABLE_SIZE] = '{
      8'd136, 8'd152, 8'd168, 8'd176, 8'd144, 8'd72,  8'd88,  8'd104,
      8'd112, 8'd80,  8'd8,   8'd24,  8'd40,  8'd48,  8'd16,  8'd208};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINISH,
      ST_PUBLISH
   } npir_state_type;

   typedef struct packed {
      logic load;
      logic issue;
      logic publish;
   } npir_cmd_type;

   typedef struct packed {
      logic dark;
      logic issue_last;
      logic out_free;
   } npir_status_type;

endpackage

FILE: src/npir_ctrl.sv
module npir_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  npir_pkg::npir_status_type status,
   output npir_pkg::npir_cmd_type    cmd,
   output logic                     req_stall
);
   import npir_pkg::*;

   npir_state_type state_ff;
   npir_state_type state_in;
   logic           req_take;

   assign req_take = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && !status.dark) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (status.issue_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_PUBLISH;
         end
         ST_PUBLISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_take;
         end
         ST_SEARCH: begin
            cmd.issue = 1'b1;
         end
         ST_FINISH: begin
            cmd = '0;
         end
         ST_PUBLISH: begin
            cmd.publish = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/npir_dpath.sv
module npir_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  npir_pkg::npir_cmd_type           cmd,
   output npir_pkg::npir_status_type        status,
   input  logic [npir_pkg::CHAN_W-1:0]      dark_threshold,
   input  logic [npir_pkg::CHAN_W-1:0]      req_red,
   input  logic [npir_pkg::CHAN_W-1:0]      req_green,
   input  logic [npir_pkg::CHAN_W-1:0]      req_blue,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [npir_pkg::BYTE_W-1:0]      rsp_address_byte,
   output logic [npir_pkg::BYTE_W-1:0]      rsp_address_inverse,
   output logic [npir_pkg::BYTE_W-1:0]      rsp_command_byte,
   output logic [npir_pkg::BYTE_W-1:0]      rsp_command_inverse,
   output logic [npir_pkg::IDX_W-1:0]       rsp_palette_index,
   output logic [npir_pkg::DIST_W-1:0]      rsp_best_distance
);
   import npir_pkg::*;

   // captured color
   logic [CHAN_W-1:0] red_ff,   red_in;
   logic [CHAN_W-1:0] green_ff, green_in;
   logic [CHAN_W-1:0] blue_ff,  blue_in;
   logic [IDX_W-1:0]  idx_ff,   idx_in;

   // square stage
   logic [CHAN_W-1:0] dr, dg, db;
   logic [SQ_W-1:0]   sq_r_ff, sq_r_in;
   logic [SQ_W-1:0]   sq_g_ff, sq_g_in;
   logic [SQ_W-1:0]   sq_b_ff, sq_b_in;
   logic [IDX_W-1:0]  p_idx_ff, p_idx_in;
   logic              p_vld_ff, p_vld_in;

   // compare stage
   logic [DIST_W-1:0] cand_dist;
   logic              take_new;
   logic [DIST_W-1:0] best_d_ff, best_d_in;
   logic [IDX_W-1:0]  best_i_ff, best_i_in;

   // output register
   logic              out_vld_ff, out_vld_in;
   logic [BYTE_W-1:0] out_cmd_ff, out_cmd_in;
   logic [IDX_W-1:0]  out_idx_ff, out_idx_in;
   logic [DIST_W-1:0] out_dist_ff, out_dist_in;

   assign status.dark = (req_red < dark_threshold) && (req_green < dark_threshold) &&
                        (req_blue < dark_threshold);
   assign status.issue_last = (idx_ff == LAST_IDX);
   assign status.out_free   = !out_vld_ff || !rsp_stall;

   always_comb begin
      red_in   = red_ff;
      green_in = green_ff;
      blue_in  = blue_ff;
      idx_in   = idx_ff;
      if (cmd.load) begin
         red_in   = req_red;
         green_in = req_green;
         blue_in  = req_blue;
         idx_in   = '0;
      end else if (cmd.issue) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   // absolute differences against the current palette entry
   always_comb begin
      dr = (red_ff >= PAL_RED[idx_ff]) ? red_ff - PAL_RED[idx_ff] : PAL_RED[idx_ff] - red_ff;
      dg = (green_ff >= PAL_GREEN[idx_ff]) ? green_ff - PAL_GREEN[idx_ff] :
           PAL_GREEN[idx_ff] - green_ff;
      db = (blue_ff >= PAL_BLUE[idx_ff]) ? blue_ff - PAL_BLUE[idx_ff] :
           PAL_BLUE[idx_ff] - blue_ff;
      sq_r_in  = SQ_W'(dr) * SQ_W'(dr);
      sq_g_in  = SQ_W'(dg) * SQ_W'(dg);
      sq_b_in  = SQ_W'(db) * SQ_W'(db);
      p_idx_in = idx_ff;
      p_vld_in = cmd.issue;
   end

   // running minimum, first entry always taken, ties keep the lower index
   always_comb begin
      cand_dist = DIST_W'(sq_r_ff) + DIST_W'(sq_g_ff) + DIST_W'(sq_b_ff);
      take_new  = p_vld_ff && ((p_idx_ff == '0) || (cand_dist < best_d_ff));
      best_d_in = take_new ? cand_dist : best_d_ff;
      best_i_in = take_new ? p_idx_ff : best_i_ff;
   end

   always_comb begin
      out_vld_in  = out_vld_ff && rsp_stall;
      out_cmd_in  = out_cmd_ff;
      out_idx_in  = out_idx_ff;
      out_dist_in = out_dist_ff;
      if (cmd.publish) begin
         out_vld_in  = 1'b1;
         out_cmd_in  = PAL_CODE[best_i_ff];
         out_idx_in  = best_i_ff;
         out_dist_in = best_d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         p_vld_ff   <= p_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      red_ff      <= red_in;
      green_ff    <= green_in;
      blue_ff     <= blue_in;
      idx_ff      <= idx_in;
      sq_r_ff     <= sq_r_in;
      sq_g_ff     <= sq_g_in;
      sq_b_ff     <= sq_b_in;
      p_idx_ff    <= p_idx_in;
      best_d_ff   <= best_d_in;
      best_i_ff   <= best_i_in;
      out_cmd_ff  <= out_cmd_in;
      out_idx_ff  <= out_idx_in;
      out_dist_ff <= out_dist_in;
   end

   assign rsp_valid           = out_vld_ff;
   assign rsp_address_byte    = IR_ADDR_BYTE;
   assign rsp_address_inverse = IR_ADDR_INVERSE;
   assign rsp_command_byte    = out_cmd_ff;
   assign rsp_command_inverse = ~out_cmd_ff;
   assign rsp_palette_index   = out_idx_ff;
   assign rsp_best_distance   = out_dist_ff;

endmodule

FILE: src/nearest_palette_ir_command.sv
// nearest palette color to infrared remote frame
//
// req channel: one rgb color (req_red, req_green, req_blue) per transaction,
// taken when req_valid is high and req_stall is low. colors whose three
// channels all lie below dark_threshold are dropped without a result.
// rsp channel: one four-byte ir frame (0x00, 0xff, command, ~command) plus
// the chosen palette index and its squared distance, taken when rsp_valid
// is high and rsp_stall is low.
// search: 16 palette entries are issued one per cycle into a square stage,
// the compare stage is drained, then the output register is loaded once it
// is free. the pace is set by the single shared distance unit walking the
// palette: no new color is taken until the last result is published.
// a dropped color is taken while idle and the next can follow right away.
// a stalled result sits in the output register while the next color is
// taken and searched; a new result waits until that register is free.
// reset clears the controller and the output valid, and sets dark_threshold
// to 25. csr port: dark_threshold at byte address 0, pready always high.
module nearest_palette_ir_command (
   input  logic                             clock,
   input  logic                             reset,
   // input transactions
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [npir_pkg::CHAN_W-1:0]      req_red,
   input  logic [npir_pkg::CHAN_W-1:0]      req_green,
   input  logic [npir_pkg::CHAN_W-1:0]      req_blue,
   // result transactions
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [npir_pkg::BYTE_W-1:0]      rsp_address_byte,
   output logic [npir_pkg::BYTE_W-1:0]      rsp_address_inverse,
   output logic [npir_pkg::BYTE_W-1:0]      rsp_command_byte,
   output logic [npir_pkg::BYTE_W-1:0]      rsp_command_inverse,
   output logic [npir_pkg::IDX_W-1:0]       rsp_palette_index,
   output logic [npir_pkg::DIST_W-1:0]      rsp_best_distance,
   // register port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [npir_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [npir_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [npir_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import npir_pkg::*;

   logic [CHAN_W-1:0] thr_ff, thr_in;
   logic              csr_wr;
   npir_cmd_type      cmd;
   npir_status_type   status;

   // register write in the access phase, low address bits ignored
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      thr_in = thr_ff;
      if (csr_wr && (csr_paddr[2] == REG_DARK_THRESHOLD)) begin
         thr_in = csr_pwdata[CHAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= DARK_THRESHOLD_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   // readback, unmapped words read zero
   assign csr_prdata = (csr_paddr[2] == REG_DARK_THRESHOLD) ?
                       CSR_DATA_W'(thr_ff) : '0;

   // sequencer: accept, walk palette, drain compare stage, publish
   npir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   // color capture, distance unit, running minimum and output register
   npir_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .dark_threshold      (thr_ff),
      .req_red             (req_red),
      .req_green           (req_green),
      .req_blue            (req_blue),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_address_byte    (rsp_address_byte),
      .rsp_address_inverse (rsp_address_inverse),
      .rsp_command_byte    (rsp_command_byte),
      .rsp_command_inverse (rsp_command_inverse),
      .rsp_palette_index   (rsp_palette_index),
      .rsp_best_distance   (rsp_best_distance)
   );

endmodule

FILE: src/npir_checker.sv
module npir_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [npir_pkg::BYTE_W-1:0]      rsp_address_byte,
   input logic [npir_pkg::BYTE_W-1:0]      rsp_address_inverse,
   input logic [npir_pkg::BYTE_W-1:0]      rsp_command_byte,
   input logic [npir_pkg::BYTE_W-1:0]      rsp_command_inverse,
   input logic [npir_pkg::IDX_W-1:0]       rsp_palette_index,
   input logic [npir_pkg::DIST_W-1:0]      rsp_best_distance
);
   import npir_pkg::*;

   localparam logic [DIST_W-1:0] MAX_DIST = DIST_W'(3 * 255 * 255);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_command_byte) &&
      $stable(rsp_palette_index) && $stable(rsp_best_distance))
      else $error("stalled result changed");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // frame bytes are consistent
   a_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_address_byte == IR_ADDR_BYTE) &&
      (rsp_address_inverse == IR_ADDR_INVERSE) &&
      (rsp_command_inverse == ~rsp_command_byte))
      else $error("inconsistent frame bytes");

   // command code matches the reported palette entry and distance is bounded
   a_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_command_byte == PAL_CODE[rsp_palette_index]) &&
      (rsp_best_distance <= MAX_DIST))
      else $error("command or distance out of line with palette entry");

endmodule

bind nearest_palette_ir_command npir_checker u_npir_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_address_byte    (rsp_address_byte),
   .rsp_address_inverse (rsp_address_inverse),
   .rsp_command_byte    (rsp_command_byte),
   .rsp_command_inverse (rsp_command_inverse),
   .rsp_palette_index   (rsp_palette_index),
   .rsp_best_distance   (rsp_best_distance)
);
